@@ rtl/touch_triple_sample_deadband_filter_core_macros.svh @@
// Assertion macros for the checker file of the touch filter.
`ifndef TOUCH_TRIPLE_SAMPLE_DEADBAND_FILTER_CORE_MACROS_SVH
`define TOUCH_TRIPLE_SAMPLE_DEADBAND_FILTER_CORE_MACROS_SVH

// Checked on every rising edge of clk_i while out of reset.
`define TSDF_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked on every rising edge of clk_i, reset included.
`define TSDF_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

@@ rtl/tsdf_pkg.sv @@
`timescale 1ns / 1ps

package tsdf_pkg;

  localparam int SampleWidthDefault = 12;
  localparam int TolWidth           = 12;
  localparam logic [TolWidth-1:0] TolReset = 12'd20;

  // Number of samples that make up one reading, and the averaging divisor.
  localparam int Divisor = 3;

  // Fill status of the queue between the front and the back.
  typedef struct packed {
    logic full;
    logic empty;
  } tsdf_q_stat_t;

endpackage

@@ rtl/tsdf_ifs.sv @@
`timescale 1ns / 1ps

// Sample channel: one converter sample and its axis tag per word.
interface tsdf_in_if #(
  parameter int SampleWidth = tsdf_pkg::SampleWidthDefault
);
  logic                   valid;
  logic                   ready;
  logic                   axis;
  logic [SampleWidth-1:0] sample;

  modport source (output valid, output axis, output sample, input ready);
  modport sink   (input valid, input axis, input sample, output ready);
endinterface

// Result channel: one finished reading per word.
interface tsdf_out_if #(
  parameter int SampleWidth = tsdf_pkg::SampleWidthDefault
);
  logic                   valid;
  logic                   ready;
  logic                   axis_out;
  logic [SampleWidth-1:0] position;
  logic                   rejected;

  modport source (output valid, output axis_out, output position, output rejected,
                  input ready);
  modport sink   (input valid, input axis_out, input position, input rejected,
                  output ready);
endinterface

@@ rtl/tsdf_fifo.sv @@
`timescale 1ns / 1ps

// Two-entry queue between the front and the back.
module tsdf_fifo #(
  parameter int Width = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  logic [Width-1:0]     wdata_i,
  input  logic                 pop_i,
  output logic [Width-1:0]     rdata_o,
  output tsdf_pkg::tsdf_q_stat_t stat_o
);

  localparam int Depth = 2;

  logic [Width-1:0] mem_q [Depth];
  logic             wr_ptr_q, wr_ptr_d;
  logic             rd_ptr_q, rd_ptr_d;
  logic [1:0]       cnt_q, cnt_d;

  always_comb begin
    wr_ptr_d = push_i ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop_i ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + {1'b0, push_i} - {1'b0, pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  assign rdata_o      = mem_q[rd_ptr_q];
  assign stat_o.full  = (cnt_q == 2'(Depth));
  assign stat_o.empty = (cnt_q == 2'd0);

endmodule

@@ rtl/tsdf_front.sv @@
`timescale 1ns / 1ps

// Collects three samples, checks their spread and forms their sum.
module tsdf_front #(
  parameter int SampleWidth = tsdf_pkg::SampleWidthDefault
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic [tsdf_pkg::TolWidth-1:0]   tol_i,
  tsdf_in_if.sink                         in_i,
  input  tsdf_pkg::tsdf_q_stat_t          stat_i,
  output logic                            push_o,
  output logic [SampleWidth+3:0]          push_data_o
);

  localparam int SumW = SampleWidth + 2;
  localparam int CmpW = (SampleWidth > tsdf_pkg::TolWidth) ? SampleWidth : tsdf_pkg::TolWidth;

  localparam logic [1:0] CntIdle = 2'd0;
  localparam logic [1:0] CntOne  = 2'd1;
  localparam logic [1:0] CntTwo  = 2'd2;

  logic [1:0]             count_q, count_d;
  logic                   axis_q, axis_d;
  logic [SampleWidth-1:0] buf0_q, buf0_d;
  logic [SampleWidth-1:0] buf1_q, buf1_d;
  logic                   accept;
  logic [SampleWidth-1:0] diff01, diff12;
  logic                   bad;
  logic [SumW-1:0]        sum;

  assign in_i.ready = !((count_q == CntTwo) && stat_i.full);
  assign accept     = in_i.valid && in_i.ready;

  assign diff01 = (buf0_q > buf1_q) ? (buf0_q - buf1_q) : (buf1_q - buf0_q);
  assign diff12 = (buf1_q > in_i.sample) ? (buf1_q - in_i.sample) : (in_i.sample - buf1_q);
  assign bad    = (CmpW'(diff01) > CmpW'(tol_i)) || (CmpW'(diff12) > CmpW'(tol_i));
  assign sum    = SumW'(buf0_q) + SumW'(buf1_q) + SumW'(in_i.sample);

  always_comb begin
    count_d = count_q;
    axis_d  = axis_q;
    buf0_d  = buf0_q;
    buf1_d  = buf1_q;
    push_o  = 1'b0;
    if (accept) begin
      unique case (count_q)
        CntOne: begin
          buf1_d  = in_i.sample;
          count_d = CntTwo;
        end
        CntTwo: begin
          push_o  = 1'b1;
          count_d = CntIdle;
        end
        default: begin
          axis_d  = in_i.axis;
          buf0_d  = in_i.sample;
          count_d = CntOne;
        end
      endcase
    end
  end

  assign push_data_o = {axis_q, bad, sum};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= CntIdle;
      axis_q  <= 1'b0;
    end else begin
      count_q <= count_d;
      axis_q  <= axis_d;
    end
  end

  always_ff @(posedge clk_i) begin
    buf0_q <= buf0_d;
    buf1_q <= buf1_d;
  end

endmodule

@@ rtl/tsdf_back.sv @@
`timescale 1ns / 1ps

// Divides the sum by three, applies the dead band and holds the result word.
module tsdf_back #(
  parameter int SampleWidth = tsdf_pkg::SampleWidthDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [tsdf_pkg::TolWidth-1:0] tol_i,
  input  tsdf_pkg::tsdf_q_stat_t        stat_i,
  input  logic [SampleWidth+3:0]        rdata_i,
  output logic                          pop_o,
  tsdf_out_if.source                    out_o
);

  localparam int SumW  = SampleWidth + 2;
  localparam int EntW  = SampleWidth + 4;
  localparam int KDiv  = SampleWidth + 4;
  localparam int ProdW = SumW + KDiv;
  localparam int CmpW  = (SampleWidth > tsdf_pkg::TolWidth) ? SampleWidth : tsdf_pkg::TolWidth;
  localparam int unsigned RecipInt = (1 << KDiv) / tsdf_pkg::Divisor;
  localparam logic [KDiv-1:0] Recip = KDiv'(RecipInt);

  // Stage A: estimated quotient, at most one below the true one.
  logic                   a_valid_q, a_valid_d;
  logic                   a_axis_q;
  logic                   a_bad_q;
  logic [SumW-1:0]        a_sum_q;
  logic [SampleWidth-1:0] a_quo_q;

  logic                   out_valid_q, out_valid_d;
  logic                   out_axis_q;
  logic [SampleWidth-1:0] out_pos_q;
  logic                   out_rej_q;
  logic [SampleWidth-1:0] held_q [2];

  logic [ProdW-1:0]       prod;
  logic                   load_b;
  logic                   a_ready;
  logic [SumW-1:0]        rem;
  logic [SampleWidth-1:0] avg;
  logic [SampleWidth-1:0] held_cur;
  logic [SampleWidth-1:0] held_gap;
  logic                   move;
  logic [SampleWidth-1:0] held_new;

  assign prod = ProdW'(rdata_i[SumW-1:0]) * ProdW'(Recip);

  assign load_b    = a_valid_q && (!out_valid_q || out_o.ready);
  assign a_ready   = !a_valid_q || load_b;
  assign pop_o     = a_ready && !stat_i.empty;
  assign a_valid_d = pop_o ? 1'b1 : (load_b ? 1'b0 : a_valid_q);
  assign out_valid_d = load_b ? 1'b1 : (out_o.ready ? 1'b0 : out_valid_q);

  // One correction step brings the estimate to the truncated quotient.
  assign rem  = a_sum_q - (SumW'({a_quo_q, 1'b0}) + SumW'(a_quo_q));
  assign avg  = (rem >= SumW'(tsdf_pkg::Divisor)) ? (a_quo_q + SampleWidth'(1)) : a_quo_q;

  assign held_cur = held_q[a_axis_q];
  assign held_gap = (avg > held_cur) ? (avg - held_cur) : (held_cur - avg);
  assign move     = CmpW'(held_gap) > CmpW'(tol_i);
  assign held_new = (!a_bad_q && move) ? avg : held_cur;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
      held_q[0]   <= '0;
      held_q[1]   <= '0;
    end else begin
      a_valid_q   <= a_valid_d;
      out_valid_q <= out_valid_d;
      if (load_b) begin
        held_q[a_axis_q] <= held_new;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      a_axis_q <= rdata_i[EntW-1];
      a_bad_q  <= rdata_i[EntW-2];
      a_sum_q  <= rdata_i[SumW-1:0];
      a_quo_q  <= prod[KDiv+SampleWidth-1:KDiv];
    end
    if (load_b) begin
      out_axis_q <= a_axis_q;
      out_pos_q  <= held_new;
      out_rej_q  <= a_bad_q;
    end
  end

  assign out_o.valid    = out_valid_q;
  assign out_o.axis_out = out_axis_q;
  assign out_o.position = out_pos_q;
  assign out_o.rejected = out_rej_q;

endmodule

@@ rtl/touch_triple_sample_deadband_filter_core.sv @@
`timescale 1ns / 1ps
// The third sample's sum goes through the queue, stage A and the output register.
// Throughput: one sample word per cycle while the queue has room; one result per three samples.
// The rate is set by the front's combinational spread check and the back's two-stage divide.
// Reset (rst_ni low, asynchronous): tolerance returns to 20, both held values to zero,
// the sample count to zero and the queue and output register empty; no clearing pass.

module touch_triple_sample_deadband_filter_core #(
  parameter int SampleWidth = tsdf_pkg::SampleWidthDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [tsdf_pkg::TolWidth-1:0] cfg_wdata_i,
  tsdf_in_if.sink                       in_i,
  tsdf_out_if.source                    out_o
);

  // The queue entry carries the reading's axis, its reject flag and the sum of its samples.
  localparam int EntW = SampleWidth + 4;

  // The tolerance register serves both the front's spread check and the back's dead band.
  // The user must write it only while idle, so both see one value; the block does not enforce it.
  logic [tsdf_pkg::TolWidth-1:0] tol_q, tol_d;

  assign tol_d = cfg_we_i ? cfg_wdata_i : tol_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= tsdf_pkg::TolReset;
    end else begin
      tol_q <= tol_d;
    end
  end

  tsdf_pkg::tsdf_q_stat_t q_stat;
  logic                   q_push;
  logic                   q_pop;
  logic [EntW-1:0]        q_wdata;
  logic [EntW-1:0]        q_rdata;

  // The front gathers three samples and, on the third, decides whether the spread is
  // acceptable and forms the three-sample sum. It stalls the sample channel only when
  // a third sample arrives and the queue has no room.
  tsdf_front #(
    .SampleWidth(SampleWidth)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .tol_i      (tol_q),
    .in_i       (in_i),
    .stat_i     (q_stat),
    .push_o     (q_push),
    .push_data_o(q_wdata)
  );

  // A two-entry queue lets the front keep taking samples while a result word waits.
  tsdf_fifo #(
    .Width(EntW)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .wdata_i(q_wdata),
    .pop_i  (q_pop),
    .rdata_o(q_rdata),
    .stat_o (q_stat)
  );

  // The back divides by three through a reciprocal multiply and one correction, then
  // compares the average with the held value of that axis and updates it outside the
  // dead band. A rejected reading returns the held value untouched.
  tsdf_back #(
    .SampleWidth(SampleWidth)
  ) u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .tol_i  (tol_q),
    .stat_i (q_stat),
    .rdata_i(q_rdata),
    .pop_o  (q_pop),
    .out_o  (out_o)
  );

endmodule

@@ rtl/tsdf_checker.sv @@
`timescale 1ns / 1ps
`include "touch_triple_sample_deadband_filter_core_macros.svh"

// Watches the result channel of the filter core.
module tsdf_checker #(
  parameter int SampleWidth = tsdf_pkg::SampleWidthDefault
) (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   out_valid_i,
  input logic                   out_ready_i,
  input logic                   out_axis_i,
  input logic [SampleWidth-1:0] out_position_i,
  input logic                   out_rejected_i
);

  // Last position delivered for each axis; a rejected reading must repeat it.
  logic [SampleWidth-1:0] last_pos_q [2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_pos_q[0] <= '0;
      last_pos_q[1] <= '0;
    end else if (out_valid_i && out_ready_i) begin
      last_pos_q[out_axis_i] <= out_position_i;
    end
  end

  `TSDF_ASSERT(a_out_valid_holds, out_valid_i && !out_ready_i |=> out_valid_i, "result word dropped while stalled")
  `TSDF_ASSERT(a_out_word_stable, out_valid_i && !out_ready_i |=> $stable({out_axis_i, out_position_i, out_rejected_i}), "result word changed while stalled")
  `TSDF_ASSERT_ALWAYS(a_reset_empty, !rst_ni |=> !out_valid_i, "result word present after reset")
  `TSDF_ASSERT(a_reject_holds, out_valid_i && out_rejected_i |-> out_position_i == last_pos_q[out_axis_i], "rejected reading changed the held position")

endmodule

bind touch_triple_sample_deadband_filter_core tsdf_checker #(
  .SampleWidth(SampleWidth)
) u_tsdf_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .out_axis_i    (out_o.axis_out),
  .out_position_i(out_o.position),
  .out_rejected_i(out_o.rejected)
);

@@ tb/sv/touch_triple_sample_deadband_filter_core_tb.sv @@
`timescale 1ns / 1ps

module touch_triple_sample_deadband_filter_core_tb;

  localparam int SW            = tsdf_pkg::SampleWidthDefault;
  localparam int SAMPLE_MAX    = (1 << SW) - 1;
  localparam int TOL_MAX       = (1 << tsdf_pkg::TolWidth) - 1;
  // Settling time after the last reading, with ample slack over the result path.
  localparam int SETTLE_CYCLES = 8;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int PHASE_READINGS = 78;
  localparam int RANDOM_PHASES  = 6;

  // One finished reading as it leaves the block.
  typedef struct packed {
    logic          axis;
    logic [SW-1:0] position;
    logic          rejected;
  } reading_t;

  // Tracks the filter state from the accepted sample words and keeps the
  // readings that the block still owes, oldest first.
  class touch_reading_tracker;
    logic [tsdf_pkg::TolWidth-1:0] tolerance;
    logic [SW-1:0]       held_pos[2];
    logic [SW-1:0]       first_smp;
    logic [SW-1:0]       second_smp;
    int unsigned         smp_count;
    logic                cur_axis;
    reading_t            owed_readings[$];
    int unsigned         mismatches;

    function new();
      tolerance   = tsdf_pkg::TolReset;
      held_pos[0] = '0;
      held_pos[1] = '0;
      first_smp   = '0;
      second_smp  = '0;
      smp_count   = 0;
      cur_axis    = 1'b0;
      mismatches  = 0;
    endfunction

    function int distance(int a, int b);
      return (a > b) ? a - b : b - a;
    endfunction

    function int pending();
      return owed_readings.size();
    endfunction

    function void note_sample(logic ax, logic [SW-1:0] smp);
      reading_t r;
      int       avg;
      bit       bad;
      if (smp_count == 1) begin
        second_smp = smp;
        smp_count  = 2;
      end else if (smp_count == 2) begin
        smp_count = 0;
        bad = distance(first_smp, second_smp) > int'(tolerance) ||
              distance(second_smp, smp) > int'(tolerance);
        if (!bad) begin
          avg = (int'(first_smp) + int'(second_smp) + int'(smp)) / 3;
          if (distance(avg, held_pos[cur_axis]) > int'(tolerance)) begin
            held_pos[cur_axis] = avg[SW-1:0];
          end
        end
        r.axis     = cur_axis;
        r.position = held_pos[cur_axis];
        r.rejected = bad;
        owed_readings.push_back(r);
      end else begin
        // Any other count starts a new reading; its axis is fixed here.
        cur_axis  = ax;
        first_smp = smp;
        smp_count = 1;
      end
    endfunction

    function void check_reading(reading_t got);
      reading_t want;
      if (owed_readings.size() == 0) begin
        mismatches++;
        $display("%0t: reading with none owed: axis %0d position %0d rejected %0d",
                 $time, got.axis, got.position, got.rejected);
        return;
      end
      want = owed_readings.pop_front();
      if (got.axis !== want.axis) begin
        mismatches++;
        $display("%0t: axis expected %0d actual %0d", $time, want.axis, got.axis);
      end
      if (got.position !== want.position) begin
        mismatches++;
        $display("%0t: position expected %0d actual %0d", $time, want.position, got.position);
      end
      if (got.rejected !== want.rejected) begin
        mismatches++;
        $display("%0t: rejected expected %0d actual %0d", $time, want.rejected, got.rejected);
      end
    endfunction
  endclass

  logic                clk_i  = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we;
  logic [tsdf_pkg::TolWidth-1:0] cfg_wdata;
  bit                  quiet = 1'b0;
  int unsigned         cycle_count = 0;

  touch_reading_tracker tracker = new();

  tsdf_in_if  #(.SampleWidth(SW)) smp_if ();
  tsdf_out_if #(.SampleWidth(SW)) rd_if ();

  touch_triple_sample_deadband_filter_core #(
    .SampleWidth(SW)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata),
    .in_i       (smp_if),
    .out_o      (rd_if)
  );

  // 8 ns clock period.
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Guard against a block that stops answering; the limit is generous for a correct run.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Both channels are observed at the rising edge, before any of this edge's
  // nonblocking updates land, so the handshake seen here is the one that the
  // block sees. Results are checked before the new sample is noted; a reading
  // never leaves in the same cycle as its third sample word arrives.
  always @(posedge clk_i) begin : watch
    reading_t got;
    if (rst_ni) begin
      if (rd_if.valid && rd_if.ready) begin
        got.axis     = rd_if.axis_out;
        got.position = rd_if.position;
        got.rejected = rd_if.rejected;
        tracker.check_reading(got);
      end
      if (smp_if.valid && smp_if.ready) begin
        tracker.note_sample(smp_if.axis, smp_if.sample);
      end
    end
  end

  // The result side stalls in random bursts until the final quiet phase.
  initial begin
    rd_if.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      if (!quiet && $urandom_range(0, 5) == 0) begin
        rd_if.ready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk_i);
      end
      rd_if.ready <= 1'b1;
      @(posedge clk_i);
    end
  end

  // Offers one sample word, possibly after a random idle burst, and returns at
  // the edge that accepts it. Valid is left high, so that back-to-back words
  // need no second assignment in the same time step.
  task automatic send_word(logic ax, int smp);
    if (!quiet && $urandom_range(0, 6) == 0) begin
      smp_if.valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
    smp_if.valid  <= 1'b1;
    smp_if.axis   <= ax;
    smp_if.sample <= smp[SW-1:0];
    do @(posedge clk_i); while (smp_if.ready !== 1'b1);
  endtask

  // One reading: three words, each with its own axis tag. Only the first tag
  // should matter to the block.
  task automatic send_reading(logic ax0, logic ax1, logic ax2, int a, int b, int c);
    send_word(ax0, a);
    send_word(ax1, b);
    send_word(ax2, c);
  endtask

  // Holds the sender off until every owed reading has come back, then lets the
  // pipeline settle. The first edge makes sure that the word accepted at the
  // calling edge has been noted before the owed count is looked at.
  task automatic wait_for_readings();
    smp_if.valid <= 1'b0;
    @(posedge clk_i);
    while (tracker.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // The tolerance only changes with the block idle and between whole readings.
  task automatic write_tolerance(int tol);
    wait_for_readings();
    cfg_we    <= 1'b1;
    cfg_wdata <= tol[tsdf_pkg::TolWidth-1:0];
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    tracker.tolerance = tol[tsdf_pkg::TolWidth-1:0];
  endtask

  // A random reading. Half the readings are tight clusters that pass the spread
  // check, some straddle the tolerance, some sit around the held value to
  // exercise the dead band, and the rest are noise or pinned at the rails.
  task automatic random_reading();
    int   tol;
    int   mode;
    int   base;
    int   w;
    int   v;
    int   smp[3];
    logic ax0;
    tol  = int'(tracker.tolerance);
    mode = $urandom_range(0, 9);
    ax0  = 1'($urandom_range(0, 1));
    base = $urandom_range(0, SAMPLE_MAX);
    w    = tol / 2;
    if (mode == 5 || mode == 6) begin
      w = tol + 4;
    end else if (mode == 7) begin
      base = int'(tracker.held_pos[ax0]) + int'($urandom_range(0, 2 * tol + 4)) - (tol + 2);
      w    = tol / 4;
    end else if (mode == 9) begin
      base = ($urandom_range(0, 1) == 1) ? SAMPLE_MAX : 0;
    end
    for (int k = 0; k < 3; k++) begin
      if (mode == 8) begin
        v = $urandom_range(0, SAMPLE_MAX);
      end else begin
        v = base + int'($urandom_range(0, 2 * w)) - w;
      end
      smp[k] = (v < 0) ? 0 : ((v > SAMPLE_MAX) ? SAMPLE_MAX : v);
    end
    send_reading(ax0, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                 smp[0], smp[1], smp[2]);
  endtask

  initial begin
    int tol;
    smp_if.valid  <= 1'b0;
    smp_if.axis   <= 1'b0;
    smp_if.sample <= '0;
    cfg_we        <= 1'b0;
    cfg_wdata     <= '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed readings at the reset tolerance of 20.
    send_reading(1'b0, 1'b0, 1'b0, 100, 110, 120);   // X moves from zero to 110
    send_reading(1'b1, 1'b0, 1'b0, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX); // mixed tags, top rail
    send_reading(1'b0, 1'b1, 1'b1, 110, 130, 110);   // spread equal to tolerance passes
    send_reading(1'b0, 1'b0, 1'b0, 0, 21, 21);       // spread one over: rejected
    send_reading(1'b0, 1'b0, 1'b0, 130, 130, 130);   // average on the dead band edge is held

    // Zero tolerance: any change moves the held value, any disagreement rejects.
    write_tolerance(0);
    send_reading(1'b0, 1'b0, 1'b0, 5, 5, 5);
    send_reading(1'b1, 1'b1, 1'b1, 5, 6, 5);

    // Widest tolerance: everything passes and nothing leaves the dead band.
    write_tolerance(TOL_MAX);
    send_reading(1'b1, 1'b0, 1'b1, 0, SAMPLE_MAX, 0);

    // Random phases, each at its own tolerance; the last runs with no idling.
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      case (ph)
        1:       tol = 0;
        2:       tol = TOL_MAX;
        3:       tol = $urandom_range(1, 40);
        4:       tol = int'(tsdf_pkg::TolReset);
        default: tol = $urandom_range(0, TOL_MAX);
      endcase
      write_tolerance(tol);
      quiet = (ph == RANDOM_PHASES - 1);
      for (int n = 0; n < PHASE_READINGS; n++) begin
        // Once, mid-phase, let the result side drain completely.
        if (ph == 3 && n == PHASE_READINGS / 2) begin
          wait_for_readings();
        end
        random_reading();
      end
    end

    wait_for_readings();
    if (tracker.mismatches == 0 && tracker.pending() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+rtl
rtl/tsdf_pkg.sv
rtl/tsdf_ifs.sv
rtl/tsdf_fifo.sv
rtl/tsdf_front.sv
rtl/tsdf_back.sv
rtl/touch_triple_sample_deadband_filter_core.sv
rtl/tsdf_checker.sv
tb/sv/touch_triple_sample_deadband_filter_core_tb.sv
